FILE: rtl/core/elevator_stop_planner_unit_macros.svh
// Assertion macros shared by the stop planner RTL
`ifndef ELEVATOR_STOP_PLANNER_UNIT_MACROS_SVH
`define ELEVATOR_STOP_PLANNER_UNIT_MACROS_SVH

// same-cycle implication
`define ESP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("esp assertion failed");

// next-cycle implication
`define ESP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("esp assertion failed");

`endif

FILE: rtl/core/esp_pkg.sv
// Constants and shared types of the elevator stop planner
package esp_pkg;

    localparam int FLOORS = 127;
    localparam int RIDERS = 32;
    localparam int STOPS  = 16;

    localparam int FLOOR_W = 7;
    localparam int RIDER_W = 5;
    localparam int TOTAL_W = 6;
    localparam int STOP_W  = 5;
    localparam int COL_W   = 4;
    localparam int CNT_W   = 6;
    localparam int WSUM_W  = 12;
    localparam int COST_W  = 16;
    localparam int CALC_W  = 18;
    localparam int MEM_AW  = COL_W + FLOOR_W;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [FLOOR_W-1:0] TOP_FLOOR  = FLOOR_W'(FLOORS);
    localparam logic [TOTAL_W-1:0] RIDER_CAP  = TOTAL_W'(RIDERS);
    localparam logic [STOP_W-1:0]  STOP_MAX   = STOP_W'(STOPS);
    localparam logic [STOP_W-1:0]  STOP_RESET = STOP_W'(1);

    typedef struct packed {
        logic                in_take;
        logic                pre_clear;
        logic                pre_step;
        logic                pre_write;
        logic                row_load;
        logic                k_issue;
        logic                cell_write;
        logic                bt_start;
        logic                bt_read;
        logic                bt_take;
        logic                asg_first;
        logic                asg_step;
        logic                clear_total;
        logic [FLOOR_W-1:0]  f;
        logic [FLOOR_W-1:0]  k;
        logic [RIDER_W-1:0]  r;
        logic [STOP_W-1:0]   j;
    } t_cmd;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        logic [FLOOR_W-1:0]  stop;
    } t_stat;

endpackage

FILE: rtl/core/esp_in_if.sv
// Rider input channel
interface esp_in_if;
    logic                         valid;
    logic                         ready;
    logic [esp_pkg::FLOOR_W-1:0]  rider_floor;
    logic                         last_rider;

    modport source(output valid, output rider_floor, output last_rider, input ready);
    modport sink(input valid, input rider_floor, input last_rider, output ready);
endinterface

FILE: rtl/core/esp_out_if.sv
// Stop assignment result channel
interface esp_out_if;
    logic                         valid;
    logic                         ready;
    logic [esp_pkg::RIDER_W-1:0]  rider_number;
    logic [esp_pkg::FLOOR_W-1:0]  assigned_stop;
    logic                         last_result;

    modport source(output valid, output rider_number, output assigned_stop,
                   output last_result, input ready);
    modport sink(input valid, input rider_number, input assigned_stop,
                 input last_result, output ready);
endinterface

FILE: rtl/core/esp_dp.sv
// Datapath: rider store, prefix sums, DP tables, backtrack and stop assignment
module esp_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  esp_pkg::t_cmd                i_cmd,
    input  logic [esp_pkg::FLOOR_W-1:0]  i_floor,
    input  logic [esp_pkg::STOP_W-1:0]   i_n,
    output esp_pkg::t_stat               o_stat
);

    localparam int PRE_W = esp_pkg::CNT_W + esp_pkg::WSUM_W;

    logic [esp_pkg::TOTAL_W-1:0]  r_total;
    logic [esp_pkg::FLOOR_W-1:0]  r_floors [esp_pkg::RIDERS];

    logic [PRE_W-1:0]             r_pre_mem [esp_pkg::FLOORS+1];
    logic [PRE_W-1:0]             r_pre_rd;
    logic signed [esp_pkg::COST_W-1:0] r_cost_mem [1 << esp_pkg::MEM_AW];
    logic signed [esp_pkg::COST_W-1:0] r_cost_rd;
    logic [esp_pkg::FLOOR_W-1:0]  r_par_mem [1 << esp_pkg::MEM_AW];
    logic [esp_pkg::FLOOR_W-1:0]  r_par_rd;

    logic [esp_pkg::CNT_W-1:0]    r_acc_c, r_c0, r_ct;
    logic [esp_pkg::WSUM_W-1:0]   r_acc_w, r_wt;
    logic signed [esp_pkg::CALC_W-1:0] r_pi, r_q0, r_bc, r_bestc;
    logic [esp_pkg::FLOOR_W-1:0]  r_kd, r_bp, r_best, r_cur;
    logic                         r_kv;
    logic [esp_pkg::FLOOR_W-1:0]  r_chosen [esp_pkg::STOPS];
    logic [esp_pkg::FLOOR_W-1:0]  r_s, r_cl, r_md;

    logic [esp_pkg::FLOOR_W-1:0]  sel_floor;
    logic                         hit;
    logic [esp_pkg::CNT_W-1:0]    nxt_c;
    logic [esp_pkg::WSUM_W-1:0]   nxt_w;
    logic [esp_pkg::FLOOR_W:0]    issue_sum, cmp_sum;
    logic [esp_pkg::FLOOR_W-1:0]  pre_raddr;
    logic [esp_pkg::CNT_W-1:0]    rd_c;
    logic [esp_pkg::WSUM_W-1:0]   rd_w;
    logic [12:0]                  mul_ici, mul_ict, mul_ic0, mul_kt;
    logic [13:0]                  mul_km;
    logic signed [esp_pkg::CALC_W-1:0] row_p, prev, t_term, c_val;
    logic [esp_pkg::COL_W-1:0]    col_wr, col_rd;
    logic [esp_pkg::FLOOR_W-1:0]  first_d, step_d, step_stop;

    assign sel_floor = r_floors[i_cmd.r];
    assign hit       = (sel_floor == i_cmd.f);
    assign nxt_c     = r_acc_c + esp_pkg::CNT_W'(hit);
    assign nxt_w     = r_acc_w + (hit ? esp_pkg::WSUM_W'(sel_floor) : '0);

    assign issue_sum = {1'b0, i_cmd.k} + {1'b0, i_cmd.f};
    assign cmp_sum   = {1'b0, r_kd} + {1'b0, i_cmd.f};
    assign pre_raddr = i_cmd.k_issue ? issue_sum[esp_pkg::FLOOR_W:1] : i_cmd.f;
    assign rd_c      = r_pre_rd[PRE_W-1 -: esp_pkg::CNT_W];
    assign rd_w      = r_pre_rd[esp_pkg::WSUM_W-1:0];

    assign mul_ici = {6'b0, i_cmd.f} * {7'b0, rd_c};
    assign mul_ict = {6'b0, i_cmd.f} * {7'b0, r_ct};
    assign mul_ic0 = {6'b0, i_cmd.f} * {7'b0, r_c0};
    assign mul_km  = {6'b0, cmp_sum} * {8'b0, rd_c};
    assign mul_kt  = {6'b0, r_kd} * {7'b0, r_ct};

    assign row_p = $signed({4'b0, mul_ici, 1'b0}) - $signed({5'b0, rd_w, 1'b0})
                 - $signed({5'b0, mul_ict});
    assign prev  = (i_cmd.j == esp_pkg::STOP_W'(1)) ? $signed({6'b0, r_wt})
                 : esp_pkg::CALC_W'(r_cost_rd);
    assign t_term = (r_kd == '0) ? r_q0
                  : r_pi + $signed({5'b0, rd_w, 1'b0}) - $signed({4'b0, mul_km})
                    + $signed({5'b0, mul_kt});
    assign c_val  = prev + t_term;

    assign col_wr = esp_pkg::COL_W'(i_cmd.j - esp_pkg::STOP_W'(1));
    assign col_rd = esp_pkg::COL_W'(i_cmd.j - esp_pkg::STOP_W'(2));

    assign first_d   = (sel_floor >= r_chosen[0]) ? sel_floor - r_chosen[0]
                                                  : r_chosen[0] - sel_floor;
    assign step_stop = r_chosen[i_cmd.j[esp_pkg::COL_W-1:0]];
    assign step_d    = (r_s >= step_stop) ? r_s - step_stop : step_stop - r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_kv    <= 1'b0;
        end else begin
            r_kv <= i_cmd.k_issue;
            if (i_cmd.clear_total) begin
                r_total <= '0;
            end else if (i_cmd.in_take && r_total < esp_pkg::RIDER_CAP) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take && r_total < esp_pkg::RIDER_CAP) begin
            r_floors[r_total[esp_pkg::RIDER_W-1:0]] <= i_floor;
        end
        if (i_cmd.pre_clear) begin
            r_acc_c <= '0;
            r_acc_w <= '0;
        end else if (i_cmd.pre_step) begin
            r_acc_c <= nxt_c;
            r_acc_w <= nxt_w;
        end
        if (i_cmd.pre_write) begin
            r_pre_mem[i_cmd.f] <= {nxt_c, nxt_w};
            if (i_cmd.f == '0) begin
                r_c0 <= nxt_c;
            end
            if (i_cmd.f == esp_pkg::TOP_FLOOR) begin
                r_ct <= nxt_c;
                r_wt <= nxt_w;
            end
        end
        r_pre_rd <= r_pre_mem[pre_raddr];
        if (i_cmd.row_load) begin
            r_pi <= row_p;
            r_q0 <= row_p - $signed({5'b0, mul_ic0});
        end
        r_kd      <= i_cmd.k;
        r_cost_rd <= r_cost_mem[{col_rd, i_cmd.k}];
        if (r_kv && (r_kd == '0 || c_val <= r_bc)) begin
            r_bc <= c_val;
            r_bp <= r_kd;
        end
        if (i_cmd.cell_write) begin
            r_cost_mem[{col_wr, i_cmd.f}] <= r_bc[esp_pkg::COST_W-1:0];
            r_par_mem[{col_wr, i_cmd.f}]  <= r_bp;
            if (i_cmd.j == i_n && (i_cmd.f == '0 || r_bc <= r_bestc)) begin
                r_bestc <= r_bc;
                r_best  <= i_cmd.f;
            end
        end
        if (i_cmd.bt_read) begin
            r_par_rd <= r_par_mem[{i_cmd.j[esp_pkg::COL_W-1:0], r_cur}];
        end
        if (i_cmd.bt_start) begin
            r_chosen[esp_pkg::COL_W'(i_n - esp_pkg::STOP_W'(1))] <= r_best;
            r_cur <= r_best;
        end
        if (i_cmd.bt_take) begin
            r_chosen[col_wr] <= r_par_rd;
            r_cur <= r_par_rd;
        end
        if (i_cmd.asg_first) begin
            r_s  <= sel_floor;
            r_cl <= r_chosen[0];
            r_md <= first_d;
        end else if (i_cmd.asg_step && step_d < r_md) begin
            r_md <= step_d;
            r_cl <= step_stop;
        end
    end

    assign o_stat.total = r_total;
    assign o_stat.stop  = r_cl;

endmodule

FILE: rtl/core/esp_ctrl.sv
// Sequencer for load, prefix build, DP sweep, backtrack and result issue
`include "elevator_stop_planner_unit_macros.svh"

module esp_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_last,
    input  logic                         i_out_ready,
    input  logic [esp_pkg::STOP_W-1:0]   i_n,
    input  esp_pkg::t_stat               i_stat,
    output esp_pkg::t_cmd                o_cmd,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    output logic                         o_out_last
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PRE  = 4'd1;
    localparam logic [3:0] S_ROWI = 4'd2;
    localparam logic [3:0] S_ROWL = 4'd3;
    localparam logic [3:0] S_K    = 4'd4;
    localparam logic [3:0] S_KD   = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_BT   = 4'd7;
    localparam logic [3:0] S_BTR  = 4'd8;
    localparam logic [3:0] S_BTW  = 4'd9;
    localparam logic [3:0] S_AF   = 4'd10;
    localparam logic [3:0] S_AJ   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]                   r_state, n_state;
    logic [esp_pkg::FLOOR_W-1:0]  r_f, n_f, r_k, n_k;
    logic [esp_pkg::RIDER_W-1:0]  r_r, n_r;
    logic [esp_pkg::STOP_W-1:0]   r_j, n_j;
    logic                         last_r;

    assign last_r = ({1'b0, r_r} == i_stat.total - esp_pkg::TOTAL_W'(1));

    always_comb begin
        n_state = r_state;
        n_f     = r_f;
        n_k     = r_k;
        n_r     = r_r;
        n_j     = r_j;
        o_cmd   = '0;
        o_cmd.f = r_f;
        o_cmd.k = r_k;
        o_cmd.r = r_r;
        o_cmd.j = r_j;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = last_r;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    if (i_in_last) begin
                        o_cmd.pre_clear = 1'b1;
                        n_f = '0;
                        n_r = '0;
                        n_state = S_PRE;
                    end
                end
            end
            S_PRE: begin
                o_cmd.pre_step = 1'b1;
                if (last_r) begin
                    o_cmd.pre_write = 1'b1;
                    n_r = '0;
                    if (r_f == esp_pkg::TOP_FLOOR) begin
                        n_f = '0;
                        n_j = esp_pkg::STOP_W'(1);
                        n_state = S_ROWI;
                    end else begin
                        n_f = r_f + 1'b1;
                    end
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            S_ROWI: begin
                n_state = S_ROWL;
            end
            S_ROWL: begin
                o_cmd.row_load = 1'b1;
                n_k = '0;
                n_state = S_K;
            end
            S_K: begin
                o_cmd.k_issue = 1'b1;
                if (r_k == r_f) begin
                    n_state = S_KD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_KD: begin
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.cell_write = 1'b1;
                if (r_f == esp_pkg::TOP_FLOOR) begin
                    n_f = '0;
                    if (r_j == i_n) begin
                        n_state = S_BT;
                    end else begin
                        n_j = r_j + 1'b1;
                        n_state = S_ROWI;
                    end
                end else begin
                    n_f = r_f + 1'b1;
                    n_state = S_ROWI;
                end
            end
            S_BT: begin
                o_cmd.bt_start = 1'b1;
                n_j = i_n - esp_pkg::STOP_W'(1);
                n_r = '0;
                n_state = (i_n == esp_pkg::STOP_W'(1)) ? S_AF : S_BTR;
            end
            S_BTR: begin
                o_cmd.bt_read = 1'b1;
                n_state = S_BTW;
            end
            S_BTW: begin
                o_cmd.bt_take = 1'b1;
                if (r_j == esp_pkg::STOP_W'(1)) begin
                    n_r = '0;
                    n_state = S_AF;
                end else begin
                    n_j = r_j - 1'b1;
                    n_state = S_BTR;
                end
            end
            S_AF: begin
                o_cmd.asg_first = 1'b1;
                n_j = esp_pkg::STOP_W'(1);
                n_state = S_AJ;
            end
            S_AJ: begin
                if (r_j < i_n) begin
                    o_cmd.asg_step = 1'b1;
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (last_r) begin
                        o_cmd.clear_total = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_r = r_r + 1'b1;
                        n_state = S_AF;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_f     <= '0;
            r_k     <= '0;
            r_r     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_f     <= n_f;
            r_k     <= n_k;
            r_r     <= n_r;
            r_j     <= n_j;
        end
    end

    `ESP_ASSERT_IMP(a_k_in_row, r_state == S_K, r_k <= r_f)
    `ESP_ASSERT_IMP(a_col_range, r_state == S_WR, r_j >= 5'd1 && r_j <= i_n)
    `ESP_ASSERT_IMP(a_no_overlap, o_in_ready, !o_out_valid)
    `ESP_ASSERT_NXT(a_batch_end, o_out_valid && i_out_ready && o_out_last,
                    r_state == S_IDLE && i_stat.total == '0)

endmodule

FILE: rtl/core/elevator_stop_planner_unit.sv
// Top level of the elevator stop planner
//
//  Channel    Dir  Handshake              Content
//  i_rider    in   valid/ready            rider_floor, last_rider
//  o_result   out  valid/ready            rider_number, assigned_stop, last_result
//  APB        in   psel/penable/pwrite    stop_count at byte address 0
//
// Riders load one per cycle; the batch work starts on the last rider.
// Prefix build walks each floor over all stored riders (one rider compare per cycle).
// DP sweep: per stop column and floor, states ROWI, ROWL, K (k = 0 to floor), KD, WR;
// K reads the cost table through its single read port; backtrack runs BTR, BTW per column.
// Each result passes AF, AJ and OUT plus any output stall; input is held off until
// the final result beat is taken. Synchronous active-low reset clears control only.
module elevator_stop_planner_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    esp_in_if.sink                        i_rider,
    esp_out_if.source                     o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [esp_pkg::PADDR_W-1:0]   paddr,
    input  logic [esp_pkg::PDATA_W-1:0]   pwdata,
    output logic [esp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [esp_pkg::STOP_W-1:0]  r_stop_count;
    logic [esp_pkg::STOP_W-1:0]  stops_used;
    esp_pkg::t_cmd               cmd;
    esp_pkg::t_stat              stat;
    logic                        out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= esp_pkg::STOP_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_stop_count <= pwdata[esp_pkg::STOP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : esp_pkg::PDATA_W'(r_stop_count);

    assign stops_used = (r_stop_count == '0) ? esp_pkg::STOP_W'(1)
                      : (r_stop_count > esp_pkg::STOP_MAX) ? esp_pkg::STOP_MAX
                      : r_stop_count;

    esp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rider.valid),
        .i_in_last   (i_rider.last_rider),
        .i_out_ready (o_result.ready),
        .i_n         (stops_used),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (i_rider.ready),
        .o_out_valid (o_result.valid),
        .o_out_last  (out_last)
    );

    esp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_floor (i_rider.rider_floor),
        .i_n     (stops_used),
        .o_stat  (stat)
    );

    assign o_result.rider_number  = cmd.r;
    assign o_result.assigned_stop = stat.stop;
    assign o_result.last_result   = out_last;

endmodule
